/* rtl/two_way_block_cache_tags_unit_macros.svh */
// Assertion macros for the block cache tag unit.
// Users must have clk and arst_n in scope; bodies vanish under SYNTHESIS.
`ifndef TWO_WAY_BLOCK_CACHE_TAGS_UNIT_MACROS_SVH
`define TWO_WAY_BLOCK_CACHE_TAGS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BTC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("btc: assertion failed");
`define BTC_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("btc: forbidden condition seen");
`else
`define BTC_ASSERT(label, prop)
`define BTC_ASSERT_NEVER(label, cond)
`endif
`endif

/* rtl/btc_pkg.sv */
// Shared constants and types of the two-way block cache tag unit.
// No dependencies.
`default_nettype none

package btc_pkg;

	localparam int unsigned NUM_SETS    = 512;
	localparam int unsigned BLOCK_BYTES = 32768;
	localparam int unsigned MAX_FILES   = 256;

	localparam int unsigned SET_W      = $clog2(NUM_SETS);
	localparam int unsigned FILE_W     = 8;
	localparam int unsigned BLOCK_W    = 48;
	localparam int unsigned BYTES_W    = 16;
	localparam int unsigned SET_IDX_W  = 9;

	localparam int unsigned HASH_SHIFT = 17;
	localparam int unsigned HASH_W     = HASH_SHIFT + SET_W;
	localparam logic [63:0] HASH_FILE_MUL  = 64'h0000_0100_0000_01B3;
	localparam logic [63:0] HASH_BLOCK_MUL = 64'h9E37_79B9_7F4A_7C15;

	localparam logic REQ_ACCESS = 1'b0;
	localparam logic REQ_INVAL  = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [FILE_W-1:0]  file_id;
		logic [BLOCK_W-1:0] block_index;
		logic [BYTES_W-1:0] bytes;
	} way_t;

	// one memory row holds a whole set
	typedef struct packed {
		logic       recent;
		way_t [1:0] way;
	} row_t;

	typedef struct packed {
		logic               req_type;
		logic [FILE_W-1:0]  file_id;
		logic [BLOCK_W-1:0] block_index;
		logic               fill_ok;
		logic [BYTES_W-1:0] fill_bytes;
	} req_t;

	typedef struct packed {
		logic               bypass;
		logic               hit;
		logic               served;
		logic               way_used;
		logic [BYTES_W-1:0] present_bytes;
	} lk_res_t;

endpackage

`default_nettype wire

/* rtl/btc_req_if.sv */
// Request channel of the block cache tag unit: valid/ready plus the request fields.
// Depends on btc_pkg.
`default_nettype none

interface btc_req_if
	import btc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [FILE_W-1:0]  file_id;
	logic [BLOCK_W-1:0] block_index;
	logic               fill_ok;
	logic [BYTES_W-1:0] fill_bytes;

	modport source (output valid, req_type, file_id, block_index, fill_ok, fill_bytes,
		input ready);
	modport sink (input valid, req_type, file_id, block_index, fill_ok, fill_bytes,
		output ready);
endinterface

`default_nettype wire

/* rtl/btc_rsp_if.sv */
// Response channel of the block cache tag unit: valid/ready plus the result fields.
// Depends on btc_pkg.
`default_nettype none

interface btc_rsp_if
	import btc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 served;
	logic [SET_IDX_W-1:0] set_index;
	logic                 way_used;
	logic [BYTES_W-1:0]   present_bytes;

	modport source (output valid, hit, served, set_index, way_used, present_bytes,
		input ready);
	modport sink (input valid, hit, served, set_index, way_used, present_bytes,
		output ready);
endinterface

`default_nettype wire

/* rtl/btc_hash.sv */
// Set hash of the block cache tag unit: registered products, xor and slice.
// Depends on btc_pkg.
`default_nettype none

module btc_hash
	import btc_pkg::*;
(
	input  wire                 clk,
	input  wire                 load,
	input  wire [FILE_W-1:0]    file_id,
	input  wire [BLOCK_W-1:0]   block_index,
	output logic [SET_W-1:0]    set_idx
);

	// only the low HASH_W bits of each 64-bit product reach the set index
	localparam logic [HASH_W-1:0] FILE_MUL_LO  = HASH_FILE_MUL[HASH_W-1:0];
	localparam logic [HASH_W-1:0] BLOCK_MUL_LO = HASH_BLOCK_MUL[HASH_W-1:0];

	logic [HASH_W-1:0] prod_f;
	logic [HASH_W-1:0] prod_b;
	logic [HASH_W-1:0] prod_f_s1;
	logic [HASH_W-1:0] prod_b_s1;
	logic [HASH_W-1:0] key;

	assign prod_f = HASH_W'(file_id) * FILE_MUL_LO;
	assign prod_b = block_index[HASH_W-1:0] * BLOCK_MUL_LO;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_f_s1 <= prod_f;
			prod_b_s1 <= prod_b;
		end
	end

	assign key     = prod_f_s1 ^ prod_b_s1;
	assign set_idx = key[HASH_W-1:HASH_SHIFT];

endmodule

`default_nettype wire

/* rtl/btc_lookup.sv */
// Tag compare, victim choice and row update for one set of the block cache.
// Depends on btc_pkg.
`default_nettype none

module btc_lookup
	import btc_pkg::*;
(
	input  row_t               row,
	input  wire [FILE_W-1:0]   file_id,
	input  wire [BLOCK_W-1:0]  block_index,
	input  wire                fill_ok,
	input  wire [BYTES_W-1:0]  fill_bytes,
	output row_t               new_row,
	output lk_res_t            res
);

	logic               m0;
	logic               m1;
	logic               in_range;
	logic               hw;
	logic               victim;
	logic [BYTES_W-1:0] sat_bytes;

	always_comb begin
		m0 = row.way[0].valid && row.way[0].file_id == file_id
			&& row.way[0].block_index == block_index;
		m1 = row.way[1].valid && row.way[1].file_id == file_id
			&& row.way[1].block_index == block_index;
		in_range = 32'(file_id) < MAX_FILES;
		hw = !m0;
		// way 1 goes first when empty or least recently used
		victim = !row.way[1].valid || !row.recent;
		sat_bytes = (32'(fill_bytes) > BLOCK_BYTES) ? BYTES_W'(BLOCK_BYTES) : fill_bytes;

		new_row = row;
		res = '0;
		if (!in_range) begin
			res.bypass = 1'b1;
		end else if (m0 || m1) begin
			new_row.recent    = hw;
			res.hit           = 1'b1;
			res.served        = 1'b1;
			res.way_used      = hw;
			res.present_bytes = row.way[hw].bytes;
		end else begin
			res.way_used = victim;
			if (!fill_ok) begin
				new_row.way[victim].valid = 1'b0;
			end else begin
				new_row.way[victim].valid       = 1'b1;
				new_row.way[victim].file_id     = file_id;
				new_row.way[victim].block_index = block_index;
				new_row.way[victim].bytes       = sat_bytes;
				new_row.recent                  = victim;
				res.served                      = 1'b1;
				res.present_bytes               = sat_bytes;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/two_way_block_cache_tags_unit.sv */
// Two-way block cache tag unit: set memory, read-modify-write control, output register.
// Access: the set hash and then the set row are registered; ST_UPD registers the result once
// the output register is free, and takes a new access with the write-back of the set row.
// Invalidate: walks all NUM_SETS rows, one per cycle, then registers a result with all fields zero.
// Reset: a clearing pass over all NUM_SETS (512) rows empties every row; no request taken meanwhile.
// Depends on btc_pkg, btc_req_if, btc_rsp_if, btc_hash, btc_lookup and the macro header.
`default_nettype none
`include "two_way_block_cache_tags_unit_macros.svh"

module two_way_block_cache_tags_unit
	import btc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	btc_req_if.sink     req,
	btc_rsp_if.source   rsp
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_INV,
		ST_INV_LAST,
		ST_INV_DONE
	} state_t;

	localparam logic [SET_W-1:0] PTR_LAST = SET_W'(NUM_SETS - 1);

	state_t             state_q;
	state_t             state_d;
	logic [SET_W-1:0]   ptr_q;
	logic [SET_W-1:0]   ptr_s2;
	logic               inv_wb_s2;
	req_t               req_q;
	row_t               rd_row_s2;
	row_t               tag_mem_q [NUM_SETS];

	logic               accept;
	logic               slot_free;
	logic               ready;
	logic               mem_re;
	logic               mem_we;
	logic [SET_W-1:0]   raddr;
	logic [SET_W-1:0]   waddr;
	row_t               wdata;
	logic               rsp_load;
	logic [SET_W-1:0]   set_idx;
	row_t               lk_row;
	lk_res_t            lk_res;
	row_t               inv_row;
	logic               inv_in_range;

	logic                 rsp_valid_q;
	logic                 rsp_hit_q;
	logic                 rsp_served_q;
	logic [SET_IDX_W-1:0] rsp_set_q;
	logic                 rsp_way_q;
	logic [BYTES_W-1:0]   rsp_bytes_q;

	assign accept    = req.valid && ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = ready;

	btc_hash u_hash (
		.clk         (clk),
		.load        (accept),
		.file_id     (req.file_id),
		.block_index (req.block_index),
		.set_idx     (set_idx)
	);

	btc_lookup u_lookup (
		.row         (rd_row_s2),
		.file_id     (req_q.file_id),
		.block_index (req_q.block_index),
		.fill_ok     (req_q.fill_ok),
		.fill_bytes  (req_q.fill_bytes),
		.new_row     (lk_row),
		.res         (lk_res)
	);

	// invalidate write-back: drop every way owned by the named file
	always_comb begin
		inv_in_range = 32'(req_q.file_id) < MAX_FILES;
		inv_row = rd_row_s2;
		for (int w = 0; w < 2; w++) begin
			if (inv_in_range && rd_row_s2.way[w].valid
					&& rd_row_s2.way[w].file_id == req_q.file_id) begin
				inv_row.way[w].valid = 1'b0;
			end
		end
	end

	always_comb begin
		ready    = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		raddr    = set_idx;
		waddr    = set_idx;
		wdata    = lk_row;
		rsp_load = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				waddr  = ptr_q;
				wdata  = '0;
				if (ptr_q == PTR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ready = 1'b1;
			end
			ST_READ: begin
				mem_re  = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				// hold here until the output register can take the result
				if (slot_free) begin
					ready    = 1'b1;
					mem_we   = !lk_res.bypass;
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_INV: begin
				mem_re = 1'b1;
				raddr  = ptr_q;
				mem_we = inv_wb_s2;
				waddr  = ptr_s2;
				wdata  = inv_row;
				if (ptr_q == PTR_LAST) begin
					state_d = ST_INV_LAST;
				end
			end
			ST_INV_LAST: begin
				mem_we  = 1'b1;
				waddr   = ptr_s2;
				wdata   = inv_row;
				state_d = ST_INV_DONE;
			end
			ST_INV_DONE: begin
				if (slot_free) begin
					ready    = 1'b1;
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
		if (accept) begin
			state_d = (req.req_type == REQ_INVAL) ? ST_INV : ST_READ;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem_q[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_row_s2 <= tag_mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			ptr_q        <= '0;
			inv_wb_s2    <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_hit_q    <= 1'b0;
			rsp_served_q <= 1'b0;
			rsp_set_q    <= '0;
			rsp_way_q    <= 1'b0;
			rsp_bytes_q  <= '0;
		end else begin
			state_q   <= state_d;
			inv_wb_s2 <= (state_q == ST_INV);
			if (accept) begin
				ptr_q <= '0;
			end else if (state_q == ST_CLEAR || state_q == ST_INV) begin
				ptr_q <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
				if (state_q == ST_UPD) begin
					rsp_hit_q    <= lk_res.hit;
					rsp_served_q <= lk_res.served;
					rsp_set_q    <= SET_IDX_W'(set_idx);
					rsp_way_q    <= lk_res.way_used;
					rsp_bytes_q  <= lk_res.present_bytes;
				end else begin
					rsp_hit_q    <= 1'b0;
					rsp_served_q <= 1'b0;
					rsp_set_q    <= '0;
					rsp_way_q    <= 1'b0;
					rsp_bytes_q  <= '0;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_s2 <= ptr_q;
		if (accept) begin
			req_q.req_type    <= req.req_type;
			req_q.file_id     <= req.file_id;
			req_q.block_index <= req.block_index;
			req_q.fill_ok     <= req.fill_ok;
			req_q.fill_bytes  <= req.fill_bytes;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.hit           = rsp_hit_q;
	assign rsp.served        = rsp_served_q;
	assign rsp.set_index     = rsp_set_q;
	assign rsp.way_used      = rsp_way_q;
	assign rsp.present_bytes = rsp_bytes_q;

	`BTC_ASSERT(a_hit_is_served, rsp.valid && rsp.hit |-> rsp.served)
	`BTC_ASSERT(a_unserved_no_bytes, rsp.valid && !rsp.served |-> rsp.present_bytes == '0)
	`BTC_ASSERT(a_access_reads_set, accept && req.req_type == REQ_ACCESS |=> state_q == ST_READ)
	`BTC_ASSERT_NEVER(a_no_accept_in_clear, state_q == ST_CLEAR && req.ready)

endmodule

`default_nettype wire
